/* hw/rtl/pesc_pkg.sv */
// Shared types, widths, register indexes and the square root step for the servo core.
package pesc_pkg;

   localparam int PoseW   = 24;
   localparam int ErrW    = PoseW + 1;
   localparam int GainW   = 16;
   localparam int ProdW   = ErrW + GainW;
   localparam int ShProdW = ProdW - 12;
   localparam int LimW    = 23;
   localparam int TolW    = 24;
   localparam int SqW     = 2 * ErrW - 1;
   localparam int SumW    = SqW + 2;
   localparam int RootW   = 26;
   localparam int RadW    = 2 * RootW;
   localparam int RemW    = RootW + 1;
   localparam int ConfW   = 16;
   localparam int CsrDataW = 24;
   localparam int CsrIdxW  = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_GAIN_XY    = 3'd0,
      CSR_GAIN_Z     = 3'd1,
      CSR_GAIN_YAW   = 3'd2,
      CSR_MAX_LIN    = 3'd3,
      CSR_MAX_TURN   = 3'd4,
      CSR_LIN_TOL    = 3'd5,
      CSR_TURN_TOL   = 3'd6
   } csr_index_type;

   localparam logic signed [GainW-1:0] GainReset    = 16'sd4096;
   localparam logic [LimW-1:0]         MaxLinReset  = 23'd410;
   localparam logic [LimW-1:0]         MaxTurnReset = 23'd40960;
   localparam logic [TolW-1:0]         LinTolReset  = 24'd20;
   localparam logic [TolW-1:0]         TurnTolReset = 24'd4096;

   // enables for the three lane stages
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } lane_ctl_type;

   // result fields that ride alongside the square root pipeline
   typedef struct packed {
      logic signed [PoseW-1:0] vel_x;
      logic signed [PoseW-1:0] vel_y;
      logic signed [PoseW-1:0] vel_z;
      logic signed [PoseW-1:0] turn_rate;
      logic [ConfW-1:0]        conf;
      logic                    reached;
   } side_type;

   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
      logic [RadW-1:0]  rad;
   } sqrt_state_type;

   // one restoring step: bring down two radicand bits, try the next root bit
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s);
      logic [RemW+1:0] rem_sh;
      logic [RemW+1:0] trial;
      sqrt_state_type  r;
      rem_sh = {s.rem, s.rad[RadW-1 -: 2]};
      trial  = {1'b0, s.root, 2'b01};
      r.rad  = {s.rad[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
         r.rem  = RemW'(rem_sh - trial);
         r.root = {s.root[RootW-2:0], 1'b1};
      end else begin
         r.rem  = rem_sh[RemW-1:0];
         r.root = {s.root[RootW-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/pesc_lane.sv */
// One axis lane: error, gain product, squared error, tolerance check, saturation.
module pesc_lane (
   input  logic                                   clock,
   input  pesc_pkg::lane_ctl_type                 ctl,
   input  logic signed [pesc_pkg::PoseW-1:0]      cur,
   input  logic signed [pesc_pkg::PoseW-1:0]      tgt,
   input  logic signed [pesc_pkg::GainW-1:0]      gain,
   input  logic [pesc_pkg::LimW-1:0]              limit,
   input  logic [pesc_pkg::TolW-1:0]              tol,
   output logic signed [pesc_pkg::PoseW-1:0]      cmd,
   output logic [pesc_pkg::SqW-1:0]               sq,
   output logic                                   in_tol
);
   import pesc_pkg::*;

   logic signed [ErrW-1:0]    err_ff, err_in;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   logic [SqW-1:0]            sq_ff, sq_in;
   logic                      in_tol_ff, in_tol_in;
   logic signed [PoseW-1:0]   cmd_ff, cmd_in;
   logic [ErrW-1:0]           abs_err;
   logic signed [ShProdW-1:0] shifted;
   logic signed [ShProdW-1:0] lim_s;

   assign err_in    = ErrW'(tgt) - ErrW'(cur);
   assign abs_err   = err_ff[ErrW-1] ? ErrW'(-err_ff) : ErrW'(err_ff);
   assign prod_in   = ProdW'(err_ff) * ProdW'(gain);
   assign sq_in     = SqW'(abs_err * abs_err);
   assign in_tol_in = abs_err <= ErrW'(tol);

   // arithmetic shift gives the floor
   assign shifted = ShProdW'(prod_ff >>> 12);
   assign lim_s   = ShProdW'({1'b0, limit});

   always_comb begin
      if (shifted > lim_s) begin
         cmd_in = PoseW'(lim_s);
      end else if (shifted < -lim_s) begin
         cmd_in = PoseW'(-lim_s);
      end else begin
         cmd_in = PoseW'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         err_ff <= err_in;
      end
      if (ctl.en2) begin
         prod_ff   <= prod_in;
         sq_ff     <= sq_in;
         in_tol_ff <= in_tol_in;
      end
      if (ctl.en3) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd    = cmd_ff;
   assign sq     = sq_ff;
   assign in_tol = in_tol_ff;

endmodule

/* hw/rtl/pesc_isqrt.sv */
// Pipelined floor square root, one root bit per stage, with side fields carried along.
module pesc_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [pesc_pkg::SumW-1:0]     radicand,
   input  pesc_pkg::side_type            in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [pesc_pkg::RootW-1:0]    root,
   output pesc_pkg::side_type            out_side
);
   import pesc_pkg::*;

   localparam int Stages = RootW;

   sqrt_state_type st_ff   [Stages];
   side_type       side_ff [Stages];
   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] en;
   sqrt_state_type first;

   assign first.rem  = '0;
   assign first.root = '0;
   assign first.rad  = RadW'(radicand);

   always_comb begin
      en[Stages-1] = !vld_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         st_ff[0]   <= sqrt_step(first);
         side_ff[0] <= in_side;
      end
      for (int k = 1; k < Stages; k++) begin
         if (en[k]) begin
            st_ff[k]   <= sqrt_step(st_ff[k-1]);
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[Stages-1];
   assign root      = st_ff[Stages-1].root;
   assign out_side  = side_ff[Stages-1];

endmodule

/* hw/rtl/pose_error_servo_command_core.sv */
// Top level of the proportional pose servo: registers, four axis lanes, merge, square root.
//
//   channel | direction | handshake             | contents
//   req_    | in        | req_valid/req_ready   | current and target pose, confidence
//   rsp_    | out       | rsp_valid/rsp_ready   | velocities, yaw rate, confidence, norm, flag
//   csr_    | in        | csr_we                | register index and write data
//
// The pipeline has three lane stages (error, product and square, saturate and sum)
// followed by 26 square root stages, one root bit each. A request can enter every
// cycle unless a stall reaches the front; each stage advances when its successor
// is empty or advancing, so a stalled response holds only the stages behind it up
// to the first bubble. Reset empties the pipeline and loads the register defaults.
module pose_error_servo_command_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_cur_x,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_cur_y,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_cur_z,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_cur_yaw,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_tgt_x,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_tgt_y,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_tgt_z,
   input  logic signed [pesc_pkg::PoseW-1:0]   req_tgt_yaw,
   input  logic [pesc_pkg::ConfW-1:0]          req_tgt_confidence,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pesc_pkg::PoseW-1:0]   rsp_vel_x,
   output logic signed [pesc_pkg::PoseW-1:0]   rsp_vel_y,
   output logic signed [pesc_pkg::PoseW-1:0]   rsp_vel_z,
   output logic signed [pesc_pkg::PoseW-1:0]   rsp_turn_rate,
   output logic [pesc_pkg::ConfW-1:0]          rsp_out_confidence,
   output logic [pesc_pkg::RootW-1:0]          rsp_err_mag,
   output logic                                rsp_at_goal,
   input  logic                                csr_we,
   input  logic [pesc_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [pesc_pkg::CsrDataW-1:0]       csr_wdata
);
   import pesc_pkg::*;

   logic signed [GainW-1:0] gain_xy_ff, gain_z_ff, gain_yaw_ff;
   logic [LimW-1:0]         max_lin_ff, max_turn_ff;
   logic [TolW-1:0]         lin_tol_ff, turn_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_xy_ff  <= GainReset;
         gain_z_ff   <= GainReset;
         gain_yaw_ff <= GainReset;
         max_lin_ff  <= MaxLinReset;
         max_turn_ff <= MaxTurnReset;
         lin_tol_ff  <= LinTolReset;
         turn_tol_ff <= TurnTolReset;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAIN_XY:  gain_xy_ff  <= csr_wdata[GainW-1:0];
            CSR_GAIN_Z:   gain_z_ff   <= csr_wdata[GainW-1:0];
            CSR_GAIN_YAW: gain_yaw_ff <= csr_wdata[GainW-1:0];
            CSR_MAX_LIN:  max_lin_ff  <= csr_wdata[LimW-1:0];
            CSR_MAX_TURN: max_turn_ff <= csr_wdata[LimW-1:0];
            CSR_LIN_TOL:  lin_tol_ff  <= csr_wdata[TolW-1:0];
            CSR_TURN_TOL: turn_tol_ff <= csr_wdata[TolW-1:0];
            default: ;
         endcase
      end
   end

   // front stage control
   logic v1_ff, v2_ff, v3_ff;
   logic sq_ready;
   lane_ctl_type ctl;

   assign ctl.en3 = !v3_ff || sq_ready;
   assign ctl.en2 = !v2_ff || ctl.en3;
   assign ctl.en1 = !v1_ff || ctl.en2;
   assign req_ready = ctl.en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ctl.en1) v1_ff <= req_valid;
         if (ctl.en2) v2_ff <= v1_ff;
         if (ctl.en3) v3_ff <= v2_ff;
      end
   end

   logic signed [PoseW-1:0] cmd_x, cmd_y, cmd_z, cmd_w;
   logic [SqW-1:0]          sq_x, sq_y, sq_z, sq_w;
   logic                    in_x, in_y, in_z, in_w;

   pesc_lane u_lane_x (
      .clock(clock), .ctl(ctl), .cur(req_cur_x), .tgt(req_tgt_x), .gain(gain_xy_ff),
      .limit(max_lin_ff), .tol(lin_tol_ff), .cmd(cmd_x), .sq(sq_x), .in_tol(in_x));
   pesc_lane u_lane_y (
      .clock(clock), .ctl(ctl), .cur(req_cur_y), .tgt(req_tgt_y), .gain(gain_xy_ff),
      .limit(max_lin_ff), .tol(lin_tol_ff), .cmd(cmd_y), .sq(sq_y), .in_tol(in_y));
   pesc_lane u_lane_z (
      .clock(clock), .ctl(ctl), .cur(req_cur_z), .tgt(req_tgt_z), .gain(gain_z_ff),
      .limit(max_lin_ff), .tol(lin_tol_ff), .cmd(cmd_z), .sq(sq_z), .in_tol(in_z));
   pesc_lane u_lane_w (
      .clock(clock), .ctl(ctl), .cur(req_cur_yaw), .tgt(req_tgt_yaw), .gain(gain_yaw_ff),
      .limit(max_turn_ff), .tol(turn_tol_ff), .cmd(cmd_w), .sq(sq_w), .in_tol(in_w));

   // confidence follows its request through the front stages
   logic [ConfW-1:0] conf1_ff, conf2_ff, conf3_ff;
   logic [SumW-1:0]  sum_ff, sum_in;
   logic             reached_ff, reached_in;

   assign sum_in = SumW'(sq_x) + SumW'(sq_y) + SumW'(sq_z) + SumW'(sq_w);
   assign reached_in = in_x && in_y && in_z && in_w;

   always_ff @(posedge clock) begin
      if (ctl.en1) conf1_ff <= req_tgt_confidence;
      if (ctl.en2) conf2_ff <= conf1_ff;
      if (ctl.en3) begin
         conf3_ff   <= conf2_ff;
         sum_ff     <= sum_in;
         reached_ff <= reached_in;
      end
   end

   side_type side_in, side_out;
   assign side_in.vel_x     = cmd_x;
   assign side_in.vel_y     = cmd_y;
   assign side_in.vel_z     = cmd_z;
   assign side_in.turn_rate = cmd_w;
   assign side_in.conf      = conf3_ff;
   assign side_in.reached   = reached_ff;

   pesc_isqrt u_isqrt (
      .clock(clock), .reset(reset),
      .in_valid(v3_ff), .in_ready(sq_ready), .radicand(sum_ff), .in_side(side_in),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .root(rsp_err_mag),
      .out_side(side_out));

   assign rsp_vel_x          = side_out.vel_x;
   assign rsp_vel_y          = side_out.vel_y;
   assign rsp_vel_z          = side_out.vel_z;
   assign rsp_turn_rate      = side_out.turn_rate;
   assign rsp_out_confidence = side_out.conf;
   assign rsp_at_goal        = side_out.reached;

`ifndef SYNTH
   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !sq_ready |=> v3_ff && $stable(sum_ff) && $stable(reached_ff))
      else $error("merge stage lost or changed a held request");
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_ready)
      else $error("empty front stage refused a request");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted request not captured");
`endif

endmodule
